// ===== src/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/toit_pkg.sv =====
// package for the timestamp ordered input table
// constants, codes and the stored entry record; no dependencies
`default_nettype none
package toit_pkg;
  localparam int PLAYERS_DEF = 8;
  localparam int FRAMES_DEF  = 32;
  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] MODE_INS_CONF = 3'd0;
  localparam logic [2:0] MODE_INS_LOC  = 3'd1;
  localparam logic [2:0] MODE_PREDICT  = 3'd2;
  localparam logic [2:0] MODE_DISCARD  = 3'd3;
  localparam logic [2:0] MODE_FIND     = 3'd4;
  localparam logic [2:0] MODE_MARK     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVER     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_LOCKED   = 3'd3;
  localparam logic [2:0] ST_SKIP     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  localparam logic [1:0] TAG_CONF = 2'd0;
  localparam logic [1:0] TAG_LOC  = 2'd1;
  localparam logic [1:0] TAG_PRED = 2'd2;

  localparam logic [1:0] CFG_ASYNC = 2'd0;
  localparam logic [1:0] CFG_LOCAL = 2'd1;
  localparam logic [1:0] CFG_CONN  = 2'd2;

  typedef struct packed {
    logic [30:0] etime;
    logic        applied;
    logic [1:0]  tag;
    logic signed [7:0] ar;
    logic signed [7:0] ay;
    logic signed [7:0] ax;
    logic [1:0]  mods;
    logic [8:0]  key;
  } entry_t;
endpackage
`default_nettype wire

// ===== src/timestamp_ordered_input_table_top.sv =====
// timestamp ordered input table: per-player sorted frame tables in one memory
// depends on toit_pkg and assert_macros.svh
// each entry scanned or moved takes a read state and a check or write state, plus dispatch and write states
// one request at a time, in_ready comes back in the cycle after the result is taken
// reset clears fill counts and config; entry memory is not cleared
`default_nettype none
`include "assert_macros.svh"
module timestamp_ordered_input_table_top #(
  parameter int PLAYERS = toit_pkg::PLAYERS_DEF,
  parameter int FRAMES  = toit_pkg::FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [2:0]  in_player,
  input  wire logic [30:0] in_frame_time,
  input  wire logic [15:0] in_predict_delta,
  input  wire logic [8:0]  in_key_code,
  input  wire logic [1:0]  in_key_mods,
  input  wire logic signed [7:0] in_axis_x,
  input  wire logic signed [7:0] in_axis_y,
  input  wire logic signed [7:0] in_axis_r,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [4:0]       out_slot,
  output logic [5:0]       out_removed,
  output logic [30:0]      out_found_time,
  output logic [8:0]       out_found_key,
  output logic [1:0]       out_found_mods,
  output logic signed [7:0] out_found_axis_x,
  output logic signed [7:0] out_found_axis_y,
  output logic signed [7:0] out_found_axis_r,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int PW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int AW = PW + FW;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_PREW, S_SRD, S_SCHK, S_SHRD, S_SHWR, S_DRD, S_DCHK,
    S_LRD, S_LCHK, S_WR, S_OUT
  } state_t;

  state_t state_r;
  toit_pkg::entry_t mem [PLAYERS*FRAMES];
  toit_pkg::entry_t rd_r;
  logic [AW-1:0] raddr;
  logic          rd_en;
  logic          we;
  logic [AW-1:0] waddr;
  toit_pkg::entry_t wdata;

  logic [CW-1:0] cnt_r [PLAYERS];
  logic          async_r;
  logic [2:0]    local_r;
  logic [7:0]    conn_r;

  logic [2:0]  mode_r;
  logic [PW-1:0] pl_r;
  logic [30:0] t_r;
  logic [15:0] delta_r;
  toit_pkg::entry_t new_r;
  logic [CW-1:0] i_r, j_r, k_r, n_r;
  logic        hit_r;
  logic [5:0]  rem_r;

  logic [2:0]  o_status_r;
  logic [4:0]  o_slot_r;
  logic [5:0]  o_removed_r;
  toit_pkg::entry_t o_ent_r;

  logic        pl_ok;
  logic        remote_ok;
  logic [31:0] psum;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_status = o_status_r;
  assign out_slot = o_slot_r;
  assign out_removed = o_removed_r;
  assign out_found_time = o_ent_r.etime;
  assign out_found_key = o_ent_r.key;
  assign out_found_mods = o_ent_r.mods;
  assign out_found_axis_x = o_ent_r.ax;
  assign out_found_axis_y = o_ent_r.ay;
  assign out_found_axis_r = o_ent_r.ar;

  assign pl_ok = ({2'b0, in_player} < 5'(PLAYERS));
  assign remote_ok = !async_r && (32'(pl_r) != 32'(local_r)) && conn_r[3'(pl_r)];
  assign psum = {1'b0, rd_r.etime} + {16'd0, delta_r};

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_r <= mem[raddr];
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = {pl_r, FW'(0)};
    we = 1'b0;
    waddr = {pl_r, FW'(0)};
    wdata = new_r;
    case (state_r)
      S_PRE: begin
        rd_en = 1'b1;
        raddr = {pl_r, FW'(n_r - 1'b1)};
      end
      S_SRD, S_DRD, S_LRD: begin
        rd_en = 1'b1;
        raddr = {pl_r, FW'(i_r)};
      end
      S_SHRD: begin
        rd_en = 1'b1;
        raddr = {pl_r, FW'(k_r - 1'b1)};
      end
      S_SHWR: begin
        we = 1'b1;
        waddr = {pl_r, FW'(k_r)};
        wdata = rd_r;
      end
      S_DCHK: begin
        we = (i_r < n_r) && !(rd_r.tag == toit_pkg::TAG_PRED && !rd_r.applied);
        waddr = {pl_r, FW'(j_r)};
        wdata = rd_r;
      end
      S_WR: begin
        we = 1'b1;
        waddr = {pl_r, FW'(i_r)};
        wdata = new_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      async_r <= 1'b0;
      local_r <= 3'd0;
      conn_r <= 8'd0;
      for (int p = 0; p < PLAYERS; p++) cnt_r[p] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          toit_pkg::CFG_ASYNC: async_r <= cfg_data[0];
          toit_pkg::CFG_LOCAL: local_r <= cfg_data[2:0];
          toit_pkg::CFG_CONN:  conn_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_mode;
            pl_r <= PW'(in_player);
            t_r <= in_frame_time;
            delta_r <= in_predict_delta;
            new_r.etime <= in_frame_time;
            new_r.applied <= 1'b0;
            new_r.tag <= (in_mode == toit_pkg::MODE_INS_CONF) ? toit_pkg::TAG_CONF
                                                               : toit_pkg::TAG_LOC;
            new_r.key <= in_key_code;
            new_r.mods <= in_key_mods;
            new_r.ax <= in_axis_x;
            new_r.ay <= in_axis_y;
            new_r.ar <= in_axis_r;
            n_r <= cnt_r[PW'(in_player)];
            i_r <= '0;
            j_r <= '0;
            hit_r <= 1'b0;
            rem_r <= '0;
            o_status_r <= toit_pkg::ST_SKIP;
            o_slot_r <= '0;
            o_removed_r <= '0;
            o_ent_r <= '0;
            if (!pl_ok || in_mode > toit_pkg::MODE_MARK) state_r <= S_OUT;
            else state_r <= S_PREW;
          end
        end
        S_PREW: begin
          // dispatch once the request is registered
          case (mode_r)
            toit_pkg::MODE_INS_CONF, toit_pkg::MODE_INS_LOC: state_r <= S_SRD;
            toit_pkg::MODE_PREDICT:
              state_r <= (remote_ok && n_r != '0) ? S_PRE : S_OUT;
            toit_pkg::MODE_DISCARD: state_r <= remote_ok ? S_DRD : S_OUT;
            toit_pkg::MODE_FIND, toit_pkg::MODE_MARK: begin
              o_status_r <= toit_pkg::ST_NOTFOUND;
              state_r <= S_LRD;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_PRE: state_r <= S_SCHK;
        S_SCHK: begin
          if (mode_r == toit_pkg::MODE_PREDICT && !hit_r) begin
            // last entry read: build the predicted frame
            hit_r <= 1'b1;
            new_r.etime <= psum[31] ? toit_pkg::TIME_MAX : psum[30:0];
            t_r <= psum[31] ? toit_pkg::TIME_MAX : psum[30:0];
            new_r.tag <= toit_pkg::TAG_PRED;
            new_r.key <= '0;
            new_r.mods <= '0;
            new_r.ax <= rd_r.ax;
            new_r.ay <= rd_r.ay;
            new_r.ar <= rd_r.ar;
            state_r <= S_SRD;
          end else if (i_r < n_r && rd_r.etime < t_r) begin
            i_r <= i_r + 1'b1;
            state_r <= S_SRD;
          end else if (i_r < n_r && rd_r.etime == t_r) begin
            o_slot_r <= 5'(i_r);
            if (rd_r.tag == toit_pkg::TAG_CONF || rd_r.applied) begin
              o_status_r <= toit_pkg::ST_LOCKED;
              o_ent_r <= rd_r;
              state_r <= S_OUT;
            end else begin
              o_status_r <= toit_pkg::ST_OVER;
              o_ent_r <= new_r;
              state_r <= S_WR;
            end
          end else if (n_r >= CW'(FRAMES)) begin
            o_status_r <= toit_pkg::ST_FULL;
            state_r <= S_OUT;
          end else begin
            o_status_r <= toit_pkg::ST_OK;
            o_slot_r <= 5'(i_r);
            o_ent_r <= new_r;
            cnt_r[pl_r] <= n_r + 1'b1;
            k_r <= n_r;
            state_r <= (n_r > i_r) ? S_SHRD : S_WR;
          end
        end
        S_SRD: state_r <= S_SCHK;
        S_SHRD: state_r <= S_SHWR;
        S_SHWR: begin
          k_r <= k_r - 1'b1;
          state_r <= (k_r - 1'b1 > i_r) ? S_SHRD : S_WR;
        end
        S_WR: state_r <= S_OUT;
        S_DRD: state_r <= S_DCHK;
        S_DCHK: begin
          if (i_r < n_r) begin
            if (rd_r.tag == toit_pkg::TAG_PRED && !rd_r.applied) rem_r <= rem_r + 1'b1;
            else j_r <= j_r + 1'b1;
            i_r <= i_r + 1'b1;
            state_r <= S_DRD;
          end else begin
            cnt_r[pl_r] <= j_r;
            o_status_r <= toit_pkg::ST_OK;
            o_removed_r <= rem_r;
            state_r <= S_OUT;
          end
        end
        S_LRD: state_r <= S_LCHK;
        S_LCHK: begin
          if (i_r < n_r) begin
            if (mode_r == toit_pkg::MODE_FIND) begin
              i_r <= i_r + 1'b1;
              if (rd_r.applied) begin
                o_status_r <= toit_pkg::ST_OK;
                o_slot_r <= 5'(i_r);
                o_ent_r <= rd_r;
              end
              state_r <= S_LRD;
            end else if (rd_r.etime == t_r) begin
              // i_r stays on the hit so the write goes back to it
              o_status_r <= toit_pkg::ST_OK;
              o_slot_r <= 5'(i_r);
              o_ent_r <= rd_r;
              new_r <= {rd_r.etime, 1'b1, rd_r.tag, rd_r.ar, rd_r.ay, rd_r.ax,
                        rd_r.mods, rd_r.key};
              state_r <= S_WR;
            end else begin
              i_r <= i_r + 1'b1;
              state_r <= S_LRD;
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // S_WR writes new_r; for mark it holds the entry with applied set
  `ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid && $stable(out_status), "result dropped")
  `ASSERT_NEVER(a_busy_ready, clk, rst_n, in_ready && out_valid, "ready while result pending")
  `ASSERT_IMPL(a_full_zero, clk, rst_n, (out_valid && out_status == toit_pkg::ST_FULL) |-> out_slot == '0 && out_found_time == '0, "full result not clear")
  `ASSERT_NEVER(a_rem_only_disc, clk, rst_n, out_valid && out_removed != '0 && mode_r != toit_pkg::MODE_DISCARD, "removed on other mode")
endmodule
`default_nettype wire

// ===== test/timestamp_ordered_input_table_top_test.sv =====
// testbench for the timestamp ordered input table: random and directed requests
// checked against a behavioral table model kept in a small scoreboard class
// depends on toit_pkg and the rtl top level
`timescale 1ns / 1ps
module timestamp_ordered_input_table_top_test;

  localparam int NPLAY = 8;
  localparam int NFRAME = 32;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] player;
    logic [30:0] ftime;
    logic [15:0] delta;
    logic [8:0] key;
    logic [1:0] mods;
    logic [7:0] ax;
    logic [7:0] ay;
    logic [7:0] ar;
  } frame_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
    logic [5:0] removed;
    logic [30:0] ftime;
    logic [8:0] key;
    logic [1:0] mods;
    logic [7:0] ax;
    logic [7:0] ay;
    logic [7:0] ar;
  } frame_resp_t;

  int errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class table_board;
    toit_pkg::entry_t tbl[NPLAY][NFRAME];
    int fill[NPLAY];
    bit async_on;
    logic [2:0] local_p;
    logic [7:0] conn;
    frame_resp_t pending[$];

    function void clear();
      foreach (fill[p]) fill[p] = 0;
      async_on = 0;
      local_p = 0;
      conn = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        toit_pkg::CFG_ASYNC: async_on = val[0];
        toit_pkg::CFG_LOCAL: local_p = val[2:0];
        toit_pkg::CFG_CONN: conn = val;
        default: ;
      endcase
    endfunction

    function frame_resp_t from_entry(logic [2:0] st, int p, int i);
      frame_resp_t r;
      r = '0;
      r.status = st;
      r.slot = i[4:0];
      r.ftime = tbl[p][i].etime;
      r.key = tbl[p][i].key;
      r.mods = tbl[p][i].mods;
      r.ax = tbl[p][i].ax;
      r.ay = tbl[p][i].ay;
      r.ar = tbl[p][i].ar;
      return r;
    endfunction

    function frame_resp_t place(int p, logic [30:0] t, toit_pkg::entry_t e);
      frame_resp_t r;
      int n;
      int i;
      n = fill[p];
      i = 0;
      r = '0;
      while (i < n && tbl[p][i].etime < t) i++;
      if (i < n && tbl[p][i].etime == t) begin
        if (tbl[p][i].tag == toit_pkg::TAG_CONF || tbl[p][i].applied)
          return from_entry(toit_pkg::ST_LOCKED, p, i);
        e.etime = t;
        tbl[p][i] = e;
        return from_entry(toit_pkg::ST_OVER, p, i);
      end
      if (n >= NFRAME) begin
        r.status = toit_pkg::ST_FULL;
        return r;
      end
      for (int k = n; k > i; k--) tbl[p][k] = tbl[p][k - 1];
      fill[p] = n + 1;
      e.etime = t;
      tbl[p][i] = e;
      return from_entry(toit_pkg::ST_OK, p, i);
    endfunction

    function void note_request(frame_req_t q);
      frame_resp_t r;
      toit_pkg::entry_t e;
      int p;
      int n;
      int j;
      int hit;
      logic [31:0] sum;
      bit enabled;
      p = int'(q.player);
      n = fill[p];
      r = '0;
      r.status = toit_pkg::ST_SKIP;
      enabled = !async_on && q.player != local_p && conn[p];
      e = '0;
      e.key = q.key;
      e.mods = q.mods;
      e.ax = q.ax;
      e.ay = q.ay;
      e.ar = q.ar;
      case (q.mode)
        toit_pkg::MODE_INS_CONF, toit_pkg::MODE_INS_LOC: begin
          e.tag = (q.mode == toit_pkg::MODE_INS_CONF) ? toit_pkg::TAG_CONF : toit_pkg::TAG_LOC;
          r = place(p, q.ftime, e);
        end
        toit_pkg::MODE_PREDICT: if (enabled && n > 0) begin
          sum = {1'b0, tbl[p][n - 1].etime} + {16'd0, q.delta};
          e = tbl[p][n - 1];
          e.key = '0;
          e.mods = '0;
          e.tag = toit_pkg::TAG_PRED;
          e.applied = 0;
          r = place(p, sum[31] ? toit_pkg::TIME_MAX : sum[30:0], e);
        end
        toit_pkg::MODE_DISCARD: if (enabled) begin
          j = 0;
          for (int i = 0; i < n; i++)
            if (!(tbl[p][i].tag == toit_pkg::TAG_PRED && !tbl[p][i].applied)) begin
              tbl[p][j] = tbl[p][i];
              j++;
            end
          fill[p] = j;
          r.status = toit_pkg::ST_OK;
          r.removed = 6'(n - j);
        end
        toit_pkg::MODE_FIND: begin
          hit = -1;
          for (int i = 0; i < n; i++) if (tbl[p][i].applied) hit = i;
          if (hit >= 0) r = from_entry(toit_pkg::ST_OK, p, hit);
          else r.status = toit_pkg::ST_NOTFOUND;
        end
        toit_pkg::MODE_MARK: begin
          hit = -1;
          for (int i = 0; i < n; i++) if (hit < 0 && tbl[p][i].etime == q.ftime) hit = i;
          if (hit >= 0) begin
            tbl[p][hit].applied = 1;
            r = from_entry(toit_pkg::ST_OK, p, hit);
          end else begin
            r.status = toit_pkg::ST_NOTFOUND;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check_response(frame_resp_t got);
      frame_resp_t w;
      if (pending.size() == 0) begin
        report("unexpected response", 32'(got.status), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
      if (got.slot !== w.slot) report("slot", 32'(got.slot), 32'(w.slot));
      if (got.removed !== w.removed) report("removed", 32'(got.removed), 32'(w.removed));
      if (got.ftime !== w.ftime) report("found_time", 32'(got.ftime), 32'(w.ftime));
      if (got.key !== w.key) report("found_key", 32'(got.key), 32'(w.key));
      if (got.mods !== w.mods) report("found_mods", 32'(got.mods), 32'(w.mods));
      if (got.ax !== w.ax) report("found_axis_x", 32'(got.ax), 32'(w.ax));
      if (got.ay !== w.ay) report("found_axis_y", 32'(got.ay), 32'(w.ay));
      if (got.ar !== w.ar) report("found_axis_r", 32'(got.ar), 32'(w.ar));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  frame_req_t req = '0;
  logic out_valid;
  logic out_ready = 0;
  frame_resp_t resp;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = toit_pkg::CFG_ASYNC;
  logic [7:0] cfg_data = 0;

  table_board board = new();
  int idle_cycles = 0;
  bit hold_out = 0;
  bit stall_pattern = 0;
  logic [30:0] times_used[NPLAY][$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  timestamp_ordered_input_table_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(req.mode), .in_player(req.player), .in_frame_time(req.ftime),
    .in_predict_delta(req.delta), .in_key_code(req.key), .in_key_mods(req.mods),
    .in_axis_x(req.ax), .in_axis_y(req.ay), .in_axis_r(req.ar),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(resp.status), .out_slot(resp.slot), .out_removed(resp.removed),
    .out_found_time(resp.ftime), .out_found_key(resp.key), .out_found_mods(resp.mods),
    .out_found_axis_x(resp.ax), .out_found_axis_y(resp.ay), .out_found_axis_r(resp.ar),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // response side: sample, check and pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_response(resp);
    if (hold_out) out_ready <= 0;
    else if (stall_pattern) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays up after the request; callers drop it before any gap
  task automatic send_request(input frame_req_t q);
    req <= q;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_request(q);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * NFRAME + 10) @(posedge clk);
  endtask

  task automatic set_config(input bit a, input logic [2:0] lp, input logic [7:0] cm);
    drain();
    write_reg(toit_pkg::CFG_ASYNC, {7'b0, a});
    write_reg(toit_pkg::CFG_LOCAL, {5'b0, lp});
    write_reg(toit_pkg::CFG_CONN, cm);
    cfg_valid <= 0;
  endtask

  function automatic frame_req_t make_req(logic [2:0] m, logic [2:0] p, logic [30:0] t);
    frame_req_t q;
    q.mode = m;
    q.player = p;
    q.ftime = t;
    q.delta = 16'($urandom());
    q.key = 9'($urandom());
    q.mods = 2'($urandom());
    q.ax = 8'($urandom());
    q.ay = 8'($urandom());
    q.ar = 8'($urandom());
    return q;
  endfunction

  // reuse known times half the time so overwrite, lock and mark paths get hit
  function automatic logic [30:0] pick_time(int p);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && times_used[p].size() > 0)
      return times_used[p][$urandom_range(0, times_used[p].size() - 1)];
    if (r == 5) return $urandom_range(0, 1) ? toit_pkg::TIME_MAX : 31'd0;
    if (r == 6) return 31'($urandom());
    return 31'($urandom_range(0, 400));
  endfunction

  function automatic frame_req_t random_req(int p_hi);
    frame_req_t q;
    int p;
    int m;
    p = $urandom_range(0, p_hi);
    m = $urandom_range(0, 99);
    if (m < 30) q = make_req(toit_pkg::MODE_INS_CONF, 3'(p), pick_time(p));
    else if (m < 55) q = make_req(toit_pkg::MODE_INS_LOC, 3'(p), pick_time(p));
    else if (m < 72) q = make_req(toit_pkg::MODE_PREDICT, 3'(p), 31'd0);
    else if (m < 78) q = make_req(toit_pkg::MODE_DISCARD, 3'(p), 31'd0);
    else if (m < 84) q = make_req(toit_pkg::MODE_FIND, 3'(p), 31'd0);
    else if (m < 97) q = make_req(toit_pkg::MODE_MARK, 3'(p), pick_time(p));
    else q = make_req(3'($urandom_range(6, 7)), 3'(p), pick_time(p));
    if (q.mode == toit_pkg::MODE_PREDICT && $urandom_range(0, 3) != 0)
      q.delta = 16'($urandom_range(0, 40));
    if (q.mode == toit_pkg::MODE_INS_CONF || q.mode == toit_pkg::MODE_INS_LOC)
      times_used[p].push_back(q.ftime);
    return q;
  endfunction

  task automatic random_phase(int count, int p_hi);
    int sent;
    sent = 0;
    while (sent < count) begin
      for (int b = $urandom_range(1, 12); b > 0 && sent < count; b--) begin
        send_request(random_req(p_hi));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  initial begin
    frame_req_t q;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    board.clear();
    @(posedge clk);

    // directed: empty table cases, then extremes, lock, overwrite, full
    send_request(make_req(toit_pkg::MODE_FIND, 3'd3, 31'd0));
    send_request(make_req(toit_pkg::MODE_MARK, 3'd3, 31'd5));
    send_request(make_req(toit_pkg::MODE_PREDICT, 3'd3, 31'd0));
    send_request(make_req(toit_pkg::MODE_DISCARD, 3'd3, 31'd0));
    set_config(1'b0, 3'd0, 8'hFF);
    send_request(make_req(toit_pkg::MODE_PREDICT, 3'd3, 31'd0));
    q = make_req(toit_pkg::MODE_INS_CONF, 3'd3, toit_pkg::TIME_MAX);
    q.key = 9'h1FF; q.mods = 2'd3; q.ax = 8'h7F; q.ay = 8'h80; q.ar = 8'hFF;
    send_request(q);
    q = make_req(toit_pkg::MODE_INS_LOC, 3'd3, 31'd0);
    q.key = 9'd0; q.mods = 2'd0; q.ax = 8'h80; q.ay = 8'h7F; q.ar = 8'd0;
    send_request(q);
    send_request(make_req(toit_pkg::MODE_INS_LOC, 3'd3, toit_pkg::TIME_MAX));
    send_request(make_req(toit_pkg::MODE_INS_LOC, 3'd3, 31'd0));
    q = make_req(toit_pkg::MODE_PREDICT, 3'd3, 31'd0); q.delta = 16'hFFFF;
    send_request(q);
    q = make_req(toit_pkg::MODE_PREDICT, 3'd3, 31'd0); q.delta = 16'd0;
    send_request(q);
    send_request(make_req(toit_pkg::MODE_INS_LOC, 3'd3, 31'd100));
    send_request(make_req(toit_pkg::MODE_PREDICT, 3'd0, 31'd0));
    send_request(make_req(toit_pkg::MODE_MARK, 3'd3, 31'd0));
    send_request(make_req(toit_pkg::MODE_INS_LOC, 3'd3, 31'd0));
    send_request(make_req(toit_pkg::MODE_FIND, 3'd3, 31'd0));
    send_request(make_req(toit_pkg::MODE_MARK, 3'd3, 31'd0));
    send_request(make_req(toit_pkg::MODE_DISCARD, 3'd3, 31'd0));
    send_request(make_req(3'd6, 3'd3, 31'd0));
    send_request(make_req(3'd7, 3'd3, 31'd0));
    for (int i = 0; i < NFRAME + 1; i++)
      send_request(make_req(toit_pkg::MODE_INS_CONF, 3'd5, 31'(200 + i)));
    send_request(make_req(toit_pkg::MODE_INS_LOC, 3'd5, 31'd9999));
    send_request(make_req(toit_pkg::MODE_PREDICT, 3'd5, 31'd0));

    // long receiver hold while the sender keeps offering
    drain();
    hold_out = 1;
    fork
      random_phase(40, 7);
      begin
        repeat (400) @(posedge clk);
        hold_out = 0;
      end
    join
    stall_pattern = 1;
    set_config(1'b1, 3'd7, 8'h00);
    random_phase(200, 7);
    set_config(1'b0, 3'd7, 8'h5A);
    random_phase(450, 7);
    set_config(1'b0, 3'd2, 8'hFF);
    random_phase(450, 7);
    stall_pattern = 0;
    set_config(1'b0, 3'd0, 8'hFE);
    random_phase(450, 1);
    stall_pattern = 1;
    set_config(1'b0, 3'd4, 8'hFF);
    random_phase(300, 7);

    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/toit_pkg.sv
src/timestamp_ordered_input_table_top.sv
test/timestamp_ordered_input_table_top_test.sv
